// File: rtl/core/rast_pkg.sv
package rast_pkg;

	localparam int MAX_RANKS = 16;
	localparam int RANK_W    = 4;
	localparam int CNT_W     = 5;
	localparam int STEP_W    = 5;
	localparam int BYTE_W    = 32;
	localparam int FLOW_W    = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 32;

	localparam logic [1:0] KIND_DATA = 2'd0;
	localparam logic [1:0] KIND_LOSS = 2'd1;

	localparam logic EV_SEND = 1'b0;
	localparam logic EV_DONE = 1'b1;

	localparam logic PHASE_RS = 1'b0;
	localparam logic PHASE_AG = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_RANK_COUNT    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT_BYTES = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FLOW_BASE     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_STEP_DELAY    = 2'd3;

	typedef struct packed {
		logic [1:0]        packet_kind;
		logic [RANK_W-1:0] dest_rank;
		logic [BYTE_W-1:0] effective_bytes;
		logic [BYTE_W-1:0] wire_bytes;
	} item_t;

	typedef struct packed {
		logic [CNT_W-1:0]  rank_count;
		logic [BYTE_W-1:0] segment_bytes;
		logic [FLOW_W-1:0] flow_base;
		logic [BYTE_W-1:0] step_delay_ns;
	} cfg_t;

	typedef struct packed {
		logic              valid;
		logic              event_kind;
		logic [RANK_W-1:0] sender_rank;
		logic [RANK_W-1:0] target_rank;
		logic [FLOW_W-1:0] flow_id;
		logic              phase;
		logic [BYTE_W-1:0] delay_before_send;
		logic              all_done;
		logic [BYTE_W-1:0] lost_packets;
	} res_t;

endpackage

// File: rtl/core/rast_step_core.sv
module rast_step_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  rast_pkg::item_t item,
	input  rast_pkg::cfg_t  cfg,
	output rast_pkg::res_t  res
);

	logic [rast_pkg::STEP_W-1:0] rank_step_q [rast_pkg::MAX_RANKS];
	logic [rast_pkg::BYTE_W-1:0] rank_bytes_q [rast_pkg::MAX_RANKS];
	logic [rast_pkg::CNT_W-1:0]  ranks_done_q;
	logic [rast_pkg::BYTE_W-1:0] loss_count_q;

	logic [rast_pkg::CNT_W-1:0]  n;
	logic [rast_pkg::CNT_W-1:0]  n_m1;
	logic [rast_pkg::STEP_W-1:0] total;
	logic [rast_pkg::STEP_W-1:0] cur_step;
	logic [rast_pkg::STEP_W-1:0] next_step;
	logic [rast_pkg::BYTE_W-1:0] eff_sel;
	logic [rast_pkg::BYTE_W:0]   sum;
	logic                        active;
	logic                        is_data;
	logic                        is_loss;
	logic                        complete;
	logic                        finish;
	logic                        done_inc;
	logic [rast_pkg::CNT_W-1:0]  done_next;
	logic [rast_pkg::CNT_W-1:0]  rank_p1;

	always_comb begin
		if (cfg.rank_count == '0) begin
			n = rast_pkg::CNT_W'(1);
		end else if (cfg.rank_count > rast_pkg::CNT_W'(rast_pkg::MAX_RANKS)) begin
			n = rast_pkg::CNT_W'(rast_pkg::MAX_RANKS);
		end else begin
			n = cfg.rank_count;
		end
	end

	assign n_m1      = n - rast_pkg::CNT_W'(1);
	assign total     = {n_m1[rast_pkg::STEP_W-2:0], 1'b0};
	assign cur_step  = rank_step_q[item.dest_rank];
	assign next_step = cur_step + rast_pkg::STEP_W'(1);
	assign active    = ({1'b0, item.dest_rank} < n) && (cur_step < total);
	assign is_data   = (item.packet_kind == rast_pkg::KIND_DATA);
	assign is_loss   = (item.packet_kind == rast_pkg::KIND_LOSS);

	// zero effective size falls back to the wire size
	assign eff_sel  = (item.effective_bytes == '0) ? item.wire_bytes : item.effective_bytes;
	assign sum      = {1'b0, rank_bytes_q[item.dest_rank]} + {1'b0, eff_sel};
	assign complete = (sum >= {1'b0, cfg.segment_bytes});
	assign finish   = (next_step >= total);

	assign done_inc  = finish && (ranks_done_q < rast_pkg::CNT_W'(rast_pkg::MAX_RANKS));
	assign done_next = ranks_done_q + {{(rast_pkg::CNT_W-1){1'b0}}, done_inc};
	assign rank_p1   = {1'b0, item.dest_rank} + rast_pkg::CNT_W'(1);

	always_comb begin
		res                   = '0;
		res.valid             = en && active && is_data && complete;
		res.sender_rank       = item.dest_rank;
		res.lost_packets      = loss_count_q;
		if (finish) begin
			res.event_kind = rast_pkg::EV_DONE;
			res.all_done   = (done_next >= n);
		end else begin
			res.event_kind        = rast_pkg::EV_SEND;
			res.all_done          = (ranks_done_q >= n);
			res.flow_id           = cfg.flow_base + rast_pkg::FLOW_W'(next_step);
			res.delay_before_send = cfg.step_delay_ns;
			if ({1'b0, next_step} < {1'b0, n_m1}) begin
				// reduce-scatter: clockwise neighbour
				res.phase       = rast_pkg::PHASE_RS;
				res.target_rank = (rank_p1 == n) ? '0 : rank_p1[rast_pkg::RANK_W-1:0];
			end else begin
				// allgather: counterclockwise neighbour
				res.phase       = rast_pkg::PHASE_AG;
				res.target_rank = (item.dest_rank == '0) ? n_m1[rast_pkg::RANK_W-1:0]
				                                         : item.dest_rank - 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < rast_pkg::MAX_RANKS; i++) begin
				rank_step_q[i]  <= '0;
				rank_bytes_q[i] <= '0;
			end
			ranks_done_q <= '0;
			loss_count_q <= '0;
		end else if (en && active) begin
			if (is_loss) begin
				if (loss_count_q != '1) begin
					loss_count_q <= loss_count_q + 1'b1;
				end
			end else if (is_data) begin
				if (complete) begin
					rank_bytes_q[item.dest_rank] <= '0;
					rank_step_q[item.dest_rank]  <= next_step;
					ranks_done_q                 <= done_next;
				end else begin
					rank_bytes_q[item.dest_rank] <= sum[rast_pkg::BYTE_W-1:0];
				end
			end
		end
	end

`ifndef SYNTHESIS
	a_done_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ranks_done_q <= rast_pkg::CNT_W'(rast_pkg::MAX_RANKS))
		else $error("ranks done counter past ring maximum");

	a_loss_mono: assert property (@(posedge clk) disable iff (!arst_n)
		loss_count_q >= $past(loss_count_q))
		else $error("loss counter went backward");

	a_done_mono: assert property (@(posedge clk) disable iff (!arst_n)
		ranks_done_q >= $past(ranks_done_q))
		else $error("ranks done counter went backward");

	a_res_en: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (en && is_data))
		else $error("result without an enabled data word");
`endif

endmodule

// File: rtl/core/ring_allreduce_step_tracker_top.sv
// Ring allreduce step tracker. Each accepted s_ word is one delivered-packet event
// (s_tuser = packet kind); the block sustains one word per cycle while m_ is not stalled, and a
// result, when the event completes a segment, is presented on m_ after passing through
// the input register, then the per-rank read-modify-write of step and byte count feeds
// the result register. Stalls on m_ hold the input register once the result register is
// full. Configuration writes are taken every cycle (cfg_ready is always high) and are meant
// to land only while the block is idle. Per-rank state clears at reset.
module ring_allreduce_step_tracker_top (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,   // dest_rank[3:0], effective_bytes[35:4], wire_bytes[67:36]
	input  logic [1:0]  s_tuser,   // packet_kind[1:0]

	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [95:0] m_tdata,   // sender_rank[3:0], target_rank[7:4], flow_id[23:8],
	                               // phase[24], delay_before_send[56:25], all_done[57],
	                               // lost_packets[89:58]
	output logic [0:0]  m_tuser,   // event_kind[0]

	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	rast_pkg::cfg_t  cfg_q;
	rast_pkg::item_t item_s1;
	logic            valid_s1;
	rast_pkg::res_t  res;
	rast_pkg::res_t  res_s2;
	logic            valid_s2;
	logic            advance;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rank_count    <= rast_pkg::CNT_W'(1);
			cfg_q.segment_bytes <= rast_pkg::BYTE_W'(1);
			cfg_q.flow_base     <= rast_pkg::FLOW_W'(1);
			cfg_q.step_delay_ns <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				rast_pkg::CFG_RANK_COUNT:    cfg_q.rank_count <= cfg_data[rast_pkg::CNT_W-1:0];
				rast_pkg::CFG_SEGMENT_BYTES: cfg_q.segment_bytes <= cfg_data;
				rast_pkg::CFG_FLOW_BASE:     cfg_q.flow_base <= cfg_data[rast_pkg::FLOW_W-1:0];
				rast_pkg::CFG_STEP_DELAY:    cfg_q.step_delay_ns <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// stage 1 moves on only when the result register can take its outcome
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.packet_kind     <= s_tuser;
			item_s1.dest_rank       <= s_tdata[3:0];
			item_s1.effective_bytes <= s_tdata[35:4];
			item_s1.wire_bytes      <= s_tdata[67:36];
		end
	end

	rast_step_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.item   (item_s1),
		.cfg    (cfg_q),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= res.valid;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.valid) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tuser  = res_s2.event_kind;
	assign m_tdata  = {6'd0, res_s2.lost_packets, res_s2.all_done, res_s2.delay_before_send,
	                   res_s2.phase, res_s2.flow_id, res_s2.target_rank, res_s2.sender_rank};

endmodule

// File: dv/ring_allreduce_step_tracker_top_tb.sv
`timescale 1ns / 100ps

module ring_allreduce_step_tracker_top_tb;

	localparam logic [1:0] KIND_OTHER = 2'd2;
	localparam logic [1:0] KIND_SPARE = 2'd3;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int SETTLE_CYCLES = 6;
	localparam int MAX_REPORTS   = 40;
	localparam int HOLD_CYCLES   = 300;

	typedef struct {
		bit                        kind;
		bit [rast_pkg::RANK_W-1:0] sender;
		bit [rast_pkg::RANK_W-1:0] target;
		bit [rast_pkg::FLOW_W-1:0] flow;
		bit                        phase;
		bit [rast_pkg::BYTE_W-1:0] delay;
		bit                        all_done;
		bit [rast_pkg::BYTE_W-1:0] lost;
	} step_event_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [71:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [95:0] m_tdata;
	logic [0:0]  m_tuser;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;

	// per-rank progress as the block should hold it
	bit [rast_pkg::STEP_W-1:0] rank_step_q [rast_pkg::MAX_RANKS];
	bit [rast_pkg::BYTE_W:0]   rank_bytes_q [rast_pkg::MAX_RANKS];
	bit [rast_pkg::CNT_W-1:0]  finished_ranks;
	bit [rast_pkg::BYTE_W-1:0] loss_total;
	bit [rast_pkg::CNT_W-1:0]  ring_ranks = 5'd1;
	bit [rast_pkg::BYTE_W-1:0] seg_size = 32'd1;
	bit [rast_pkg::FLOW_W-1:0] flow_start = 16'd1;
	bit [rast_pkg::BYTE_W-1:0] send_delay = '0;

	step_event_t pending_events[$];
	int active_packets = 0;
	int mismatch_count = 0;
	int tx_idle_pct = 18;
	int rx_idle_pct = 66;
	int rx_hold_left = 0;
	int cycle_count = 0;

	ring_allreduce_step_tracker_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// receiver: random stalls, or one long hold-off when requested
	always @(posedge clk) begin
		if (rx_hold_left > 0) begin
			m_tready <= 1'b0;
			rx_hold_left <= rx_hold_left - 1;
		end else begin
			m_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	function automatic int ring_len();
		int n;
		n = ring_ranks;
		if (n == 0) n = 1;
		if (n > rast_pkg::MAX_RANKS) n = rast_pkg::MAX_RANKS;
		return n;
	endfunction

	function automatic bit ring_finished();
		int n;
		n = ring_len();
		for (int r = 0; r < n; r++)
			if (rank_step_q[r] < 2 * (n - 1)) return 1'b0;
		return 1'b1;
	endfunction

	function automatic logic [rast_pkg::RANK_W-1:0] open_rank();
		int n;
		int r;
		n = ring_len();
		r = $urandom_range(n - 1);
		for (int k = 0; k < n; k++)
			if (rank_step_q[(r + k) % n] < 2 * (n - 1))
				return rast_pkg::RANK_W'((r + k) % n);
		return rast_pkg::RANK_W'(r);
	endfunction

	function automatic void track_packet(input logic [1:0] kind,
			input logic [rast_pkg::RANK_W-1:0] rank,
			input logic [rast_pkg::BYTE_W-1:0] eff, input logic [rast_pkg::BYTE_W-1:0] wire_b);
		int n;
		int total;
		int nxt;
		logic [rast_pkg::BYTE_W-1:0] counted;
		step_event_t ev;
		n = ring_len();
		total = 2 * (n - 1);
		if (kind != rast_pkg::KIND_DATA && kind != rast_pkg::KIND_LOSS) return;
		if (rank >= n || rank_step_q[rank] >= total) return;
		active_packets++;
		if (kind == rast_pkg::KIND_LOSS) begin
			if (loss_total != '1) loss_total++;
			return;
		end
		counted = (eff == '0) ? wire_b : eff;
		rank_bytes_q[rank] = rank_bytes_q[rank] + counted;
		if (rank_bytes_q[rank] < seg_size) return;
		rank_bytes_q[rank] = '0;
		nxt = rank_step_q[rank] + 1;
		rank_step_q[rank] = rast_pkg::STEP_W'(nxt);
		ev = '{default: 0};
		ev.sender = rank;
		ev.lost = loss_total;
		if (nxt >= total) begin
			if (finished_ranks < rast_pkg::MAX_RANKS) finished_ranks++;
			ev.kind = rast_pkg::EV_DONE;
		end else begin
			ev.kind = rast_pkg::EV_SEND;
			// clockwise during reduce-scatter, counterclockwise during allgather
			if (nxt < n - 1) begin
				ev.target = rast_pkg::RANK_W'((rank + 1) % n);
				ev.phase = rast_pkg::PHASE_RS;
			end else begin
				ev.target = rast_pkg::RANK_W'((rank + n - 1) % n);
				ev.phase = rast_pkg::PHASE_AG;
			end
			ev.flow = rast_pkg::FLOW_W'(flow_start + nxt);
			ev.delay = send_delay;
		end
		ev.all_done = (finished_ranks >= n);
		pending_events = {pending_events, ev};
	endfunction

	task automatic report_mismatch(input string field, input logic [31:0] got,
			input logic [31:0] want);
		if (mismatch_count < MAX_REPORTS)
			$display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $time, field, got, want);
		mismatch_count++;
	endtask

	always @(posedge clk) begin
		step_event_t want;
		if (m_tvalid && m_tready) begin
			if (pending_events.size() == 0) begin
				report_mismatch("word with none pending", m_tdata[31:0], '0);
			end else begin
				want = pending_events.pop_front();
				if (m_tuser[0] !== want.kind)
					report_mismatch("event_kind", 32'(m_tuser[0]), 32'(want.kind));
				if (m_tdata[3:0] !== want.sender)
					report_mismatch("sender_rank", 32'(m_tdata[3:0]), 32'(want.sender));
				if (m_tdata[7:4] !== want.target)
					report_mismatch("target_rank", 32'(m_tdata[7:4]), 32'(want.target));
				if (m_tdata[23:8] !== want.flow)
					report_mismatch("flow_id", 32'(m_tdata[23:8]), 32'(want.flow));
				if (m_tdata[24] !== want.phase)
					report_mismatch("phase", 32'(m_tdata[24]), 32'(want.phase));
				if (m_tdata[56:25] !== want.delay)
					report_mismatch("delay_before_send", m_tdata[56:25], want.delay);
				if (m_tdata[57] !== want.all_done)
					report_mismatch("all_done", 32'(m_tdata[57]), 32'(want.all_done));
				if (m_tdata[89:58] !== want.lost)
					report_mismatch("lost_packets", m_tdata[89:58], want.lost);
			end
		end
	end

	task automatic send_packet(input logic [1:0] kind, input logic [rast_pkg::RANK_W-1:0] rank,
			input logic [rast_pkg::BYTE_W-1:0] eff, input logic [rast_pkg::BYTE_W-1:0] wire_b);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= {4'b0, wire_b, eff, rank};
		do @(posedge clk); while (!s_tready);
		track_packet(kind, rank, eff, wire_b);
	endtask

	task automatic write_reg(input logic [rast_pkg::CFG_IDX_W-1:0] idx,
			input logic [rast_pkg::CFG_DAT_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			rast_pkg::CFG_RANK_COUNT:    ring_ranks = value[rast_pkg::CNT_W-1:0];
			rast_pkg::CFG_SEGMENT_BYTES: seg_size = value;
			rast_pkg::CFG_FLOW_BASE:     flow_start = value[rast_pkg::FLOW_W-1:0];
			rast_pkg::CFG_STEP_DELAY:    send_delay = value;
			default: ;
		endcase
	endtask

	task automatic set_config(input logic [31:0] ranks, input logic [31:0] seg,
			input logic [31:0] base, input logic [31:0] dly);
		write_reg(rast_pkg::CFG_RANK_COUNT, ranks);
		write_reg(rast_pkg::CFG_SEGMENT_BYTES, seg);
		write_reg(rast_pkg::CFG_FLOW_BASE, base);
		write_reg(rast_pkg::CFG_STEP_DELAY, dly);
		cfg_valid <= 1'b0;
	endtask

	// events that produce no word may still be in the pipe when the queue empties
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (pending_events.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic run_random(input int quota, input int unsigned byte_max);
		int start;
		int pick;
		logic [rast_pkg::RANK_W-1:0] rank;
		start = active_packets;
		while (active_packets - start < quota && !ring_finished()) begin
			pick = $urandom_range(99);
			if (pick < 72) begin
				rank = open_rank();
				pick = $urandom_range(99);
				if (pick < 10)
					send_packet(rast_pkg::KIND_DATA, rank, '0, $urandom_range(byte_max));
				else if (pick < 14)
					send_packet(rast_pkg::KIND_DATA, rank, $urandom, $urandom);
				else
					send_packet(rast_pkg::KIND_DATA, rank, $urandom_range(byte_max, 1), $urandom);
			end else if (pick < 82) begin
				send_packet(rast_pkg::KIND_LOSS, rast_pkg::RANK_W'($urandom), $urandom, $urandom);
			end else if (pick < 92) begin
				send_packet(2'($urandom_range(KIND_SPARE, KIND_OTHER)),
					rast_pkg::RANK_W'($urandom), $urandom, $urandom);
			end else begin
				send_packet(rast_pkg::KIND_DATA, rast_pkg::RANK_W'($urandom), $urandom, $urandom);
			end
		end
	endtask

	task automatic test_directed();
		// out of reset the ring has one rank and no steps
		send_packet(rast_pkg::KIND_DATA, 4'd0, 32'd5, 32'd5);
		wait_idle();
		set_config(32'd1, 32'd1, 32'h0, 32'h0);
		send_packet(rast_pkg::KIND_DATA, 4'd0, 32'hFFFF_FFFF, 32'd0);
		wait_idle();
		// zero rank count acts as a single rank
		set_config(32'd0, 32'd1, 32'h0, 32'h0);
		send_packet(rast_pkg::KIND_DATA, 4'd0, 32'd9, 32'd9);
		send_packet(rast_pkg::KIND_LOSS, 4'd0, 32'd0, 32'd0);
		wait_idle();
		// two ranks, zero segment size, flow id wraps, largest delay
		set_config(32'd2, 32'd0, 32'h0001_FFFF, 32'hFFFF_FFFF);
		send_packet(rast_pkg::KIND_DATA, 4'd0, 32'd0, 32'd0);
		send_packet(rast_pkg::KIND_DATA, 4'd2, 32'd1, 32'd1);
		send_packet(KIND_OTHER, 4'd0, 32'd1, 32'd1);
		send_packet(KIND_SPARE, 4'd1, '1, '1);
		send_packet(rast_pkg::KIND_LOSS, 4'd1, 32'd0, 32'd0);
		send_packet(rast_pkg::KIND_DATA, 4'd0, 32'hFFFF_FFFF, 32'd0);
		send_packet(rast_pkg::KIND_DATA, 4'd0, 32'd3, 32'd3);
		send_packet(rast_pkg::KIND_LOSS, 4'd0, 32'd3, 32'd3);
		send_packet(rast_pkg::KIND_DATA, 4'd1, 32'd0, 32'hFFFF_FFFF);
		send_packet(rast_pkg::KIND_DATA, 4'd1, 32'd7, 32'd0);
		wait_idle();
		// three ranks, full-size segment, upper bits of the count ignored
		set_config(32'hFFFF_FFE3, 32'hFFFF_FFFF, 32'h0, 32'h0);
		send_packet(rast_pkg::KIND_DATA, 4'd2, 32'hFFFF_FFFF, 32'd0);
		send_packet(rast_pkg::KIND_DATA, 4'd2, 32'd0, 32'hFFFF_FFFE);
		send_packet(rast_pkg::KIND_DATA, 4'd2, 32'd1, 32'd0);
		send_packet(rast_pkg::KIND_DATA, 4'd0, 32'h8000_0000, 32'd1);
		send_packet(rast_pkg::KIND_DATA, 4'd0, 32'h8000_0000, 32'd1);
		// byte count has to carry past 32 bits
		send_packet(rast_pkg::KIND_DATA, 4'd2, 32'hFFFF_FFFE, 32'd0);
		send_packet(rast_pkg::KIND_DATA, 4'd2, 32'hFFFF_FFFF, 32'd0);
		send_packet(rast_pkg::KIND_LOSS, 4'd15, 32'd0, 32'd0);
		send_packet(rast_pkg::KIND_DATA, 4'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
	endtask

	task automatic test_random_rx_slow();
		wait_idle();
		set_config(32'd8, 32'd1000, $urandom, $urandom);
		run_random(530, 600);
	endtask

	task automatic test_random_tx_slow();
		wait_idle();
		tx_idle_pct = 66;
		rx_idle_pct = 18;
		set_config(32'd12, 32'd5000, 32'h0000_FFF0, $urandom);
		run_random(530, 3000);
	endtask

	task automatic test_backpressure();
		wait_idle();
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		set_config(32'd16, 32'd0, $urandom, $urandom);
		// every data word completes a step, and the output is held off at the start
		rx_hold_left <= HOLD_CYCLES;
		for (int i = 0; i < 40; i++)
			send_packet(rast_pkg::KIND_DATA, open_rank(), $urandom, $urandom);
	endtask

	task automatic test_random_no_idle();
		wait_idle();
		set_config(($urandom & 32'hFFFF_FFE0) | 32'd31, 32'd800, $urandom, 32'd0);
		run_random(530, 500);
	endtask

	initial begin
		arst_n <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_rx_slow();
		test_random_tx_slow();
		test_backpressure();
		test_random_no_idle();
		wait_idle();
		if (mismatch_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// File: ring_allreduce_step_tracker_top.f
rtl/core/rast_pkg.sv
rtl/core/rast_step_core.sv
rtl/core/ring_allreduce_step_tracker_top.sv
dv/ring_allreduce_step_tracker_top_tb.sv
